/* rtl/pba_pkg.sv */
// shared constants and request codes of the paged bump allocator
package pba_pkg;

	// default table size and length width
	localparam int unsigned MAX_PAGES_DEF = 16;
	localparam int unsigned LEN_BITS_DEF  = 24;

	// fixed field widths
	localparam int unsigned REQ_W  = 2;
	localparam int unsigned PAGE_W = 4;

	// minimum page size after reset
	localparam logic [31:0] DEFAULT_MIN_PAGE = 32'd16000;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ASK     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REALLOC = 2'd2;

endpackage

/* rtl/paged_bump_allocator.sv */
// top level of the paged bump allocator: request sequencer, config register, page table
//
// Use: pulse start with a request (req_type, length, old_length, ptr_page,
// ptr_offset) while busy is low; the beat is taken at that clock edge. Each
// request gives exactly one result beat: done is high for one cycle with
// granted, res_page, res_offset and moved valid. The receiver cannot stall,
// so the result is simply presented and dropped after that cycle; busy is
// already low in the done cycle, so the next request may start there.
// The user must write min_page_size through cfg_we / cfg_wdata only while the
// block is idle; the block itself does not enforce this. An allocate walks the
// page table newest first, one page per cycle through the single read port of
// the page memory, whose read data is registered. Request handling:
//   unused request code or ask on a page that is not open: refused from idle
//   ask: the pointer page is read, then the beat is given
//   allocate: the walk runs until a page fits; on a miss a page is opened if the table has room
//   realloc: served in place when its block is the tail of the pointer page
//   and fits, otherwise handled as an allocate, as when the page is not open
// Reset clears the open page count and loads the default minimum page size;
// the page memory is not cleared, since only open pages are ever read.
module paged_bump_allocator #(
	parameter int unsigned MAX_PAGES = pba_pkg::MAX_PAGES_DEF,
	parameter int unsigned LEN_BITS  = pba_pkg::LEN_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [pba_pkg::REQ_W-1:0]  req_type,
	input  logic [LEN_BITS-1:0]        length,
	input  logic [LEN_BITS-1:0]        old_length,
	input  logic [pba_pkg::PAGE_W-1:0] ptr_page,
	input  logic [LEN_BITS-1:0]        ptr_offset,
	input  logic                       cfg_we,
	input  logic [LEN_BITS-1:0]        cfg_wdata,
	output logic                       done,
	output logic                       granted,
	output logic [pba_pkg::PAGE_W-1:0] res_page,
	output logic [LEN_BITS-1:0]        res_offset,
	output logic                       moved
);

	localparam int unsigned PIDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int unsigned PO_W   = $clog2(MAX_PAGES + 1);
	localparam int unsigned CMP_W  = (PO_W > pba_pkg::PAGE_W) ? PO_W : pba_pkg::PAGE_W;
	localparam int unsigned ENT_W  = 3 * LEN_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PTR_CHK,
		ST_ALLOC,
		ST_SEARCH,
		ST_OPEN
	} state_t;

	state_t state_q;

	logic [LEN_BITS-1:0]       min_page_q;
	logic [PO_W-1:0]           pages_open_q;
	logic [PIDX_W-1:0]         k_q;
	logic [PIDX_W-1:0]         ptr_idx_q;
	logic [pba_pkg::REQ_W-1:0] type_q;
	logic [LEN_BITS-1:0]       len_q;
	logic [LEN_BITS-1:0]       old_len_q;
	logic [LEN_BITS-1:0]       poff_q;

	// memory port signals
	logic              rd_en;
	logic [PIDX_W-1:0] rd_addr;
	logic [ENT_W-1:0]  rd_data;
	logic              wr_en;
	logic [PIDX_W-1:0] wr_addr;
	logic [ENT_W-1:0]  wr_data;

	// fields of the entry just read
	logic [LEN_BITS-1:0] e_size, e_fill, e_last;
	assign e_size = rd_data[3*LEN_BITS-1:2*LEN_BITS];
	assign e_fill = rd_data[2*LEN_BITS-1:LEN_BITS];
	assign e_last = rd_data[LEN_BITS-1:0];

	// pointer page check against the open count
	logic [CMP_W-1:0] ptr_ext;
	logic [CMP_W-1:0] po_ext;
	logic             ptr_ok;
	assign ptr_ext = CMP_W'(ptr_page);
	assign po_ext  = CMP_W'(pages_open_q);
	assign ptr_ok  = ptr_ext < po_ext;

	// fit arithmetic, one bit wider so nothing wraps
	logic [LEN_BITS:0] fill_plus_len, poff_plus_len, poff_plus_old, size_ext;
	logic              search_fit, ptr_fit, is_last, is_tail;
	assign size_ext      = {1'b0, e_size};
	assign fill_plus_len = {1'b0, e_fill} + {1'b0, len_q};
	assign poff_plus_len = {1'b0, poff_q} + {1'b0, len_q};
	assign poff_plus_old = {1'b0, poff_q} + {1'b0, old_len_q};
	assign search_fit    = fill_plus_len <= size_ext;
	assign ptr_fit       = poff_plus_len <= size_ext;
	assign is_last       = e_last == poff_q;
	assign is_tail       = is_last && (poff_plus_old == {1'b0, e_fill});

	// new page size and table state
	logic [LEN_BITS-1:0] new_size;
	logic                table_full;
	logic [PO_W-1:0]     po_minus1;
	assign new_size   = (len_q < min_page_q) ? min_page_q : len_q;
	assign table_full = pages_open_q == PO_W'(MAX_PAGES);
	assign po_minus1  = pages_open_q - PO_W'(1);

	// result page numbers carried in the fixed page width
	logic [CMP_W-1:0] k_ext, ptr_idx_ext, open_ext;
	assign k_ext       = CMP_W'(k_q);
	assign ptr_idx_ext = CMP_W'(ptr_idx_q);
	assign open_ext    = CMP_W'(pages_open_q);

	// memory address and write selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q - PIDX_W'(1);
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = {e_size, fill_plus_len[LEN_BITS-1:0], e_fill};
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = ptr_ext[PIDX_W-1:0];
				rd_en   = start && ptr_ok &&
					(req_type == pba_pkg::REQ_ASK || req_type == pba_pkg::REQ_REALLOC);
			end
			ST_PTR_CHK: begin
				wr_addr = ptr_idx_q;
				wr_en   = (type_q == pba_pkg::REQ_REALLOC) && is_tail;
				wr_data = ptr_fit ? {e_size, poff_plus_len[LEN_BITS-1:0], e_last}
					: {e_size, poff_q, e_last};
			end
			ST_ALLOC: begin
				rd_addr = po_minus1[PIDX_W-1:0];
				rd_en   = pages_open_q != '0;
			end
			ST_SEARCH: begin
				wr_en = search_fit;
				rd_en = !search_fit && (k_q != '0);
			end
			ST_OPEN: begin
				wr_addr = pages_open_q[PIDX_W-1:0];
				wr_en   = !table_full;
				wr_data = {new_size, len_q, {LEN_BITS{1'b0}}};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	pba_page_mem #(
		.DEPTH  (MAX_PAGES),
		.IDX_W  (PIDX_W),
		.DATA_W (ENT_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_page_q <= LEN_BITS'(pba_pkg::DEFAULT_MIN_PAGE);
		end else if (cfg_we) begin
			min_page_q <= cfg_wdata;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			type_q    <= req_type;
			len_q     <= length;
			old_len_q <= old_length;
			poff_q    <= ptr_offset;
			ptr_idx_q <= ptr_ext[PIDX_W-1:0];
		end
	end

	// sequencer with registered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pages_open_q <= '0;
			k_q          <= '0;
			done         <= 1'b0;
			granted      <= 1'b0;
			res_page     <= '0;
			res_offset   <= '0;
			moved        <= 1'b0;
		end else begin
			done       <= 1'b0;
			granted    <= 1'b0;
			res_page   <= '0;
			res_offset <= '0;
			moved      <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (req_type)
							pba_pkg::REQ_ALLOC: begin
								state_q <= ST_ALLOC;
							end
							pba_pkg::REQ_ASK: begin
								if (ptr_ok) begin
									state_q <= ST_PTR_CHK;
								end else begin
									done <= 1'b1;
								end
							end
							pba_pkg::REQ_REALLOC: begin
								state_q <= ptr_ok ? ST_PTR_CHK : ST_ALLOC;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_PTR_CHK: begin
					if (type_q == pba_pkg::REQ_ASK) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
						if (is_last && ptr_fit) begin
							granted    <= 1'b1;
							res_page   <= ptr_idx_ext[pba_pkg::PAGE_W-1:0];
							res_offset <= poff_q;
						end
					end else if (is_tail && ptr_fit) begin
						done       <= 1'b1;
						granted    <= 1'b1;
						res_page   <= ptr_idx_ext[pba_pkg::PAGE_W-1:0];
						res_offset <= poff_q;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_ALLOC;
					end
				end
				ST_ALLOC: begin
					k_q     <= po_minus1[PIDX_W-1:0];
					state_q <= (pages_open_q == '0) ? ST_OPEN : ST_SEARCH;
				end
				ST_SEARCH: begin
					if (search_fit) begin
						done       <= 1'b1;
						granted    <= 1'b1;
						res_page   <= k_ext[pba_pkg::PAGE_W-1:0];
						res_offset <= e_fill;
						moved      <= type_q == pba_pkg::REQ_REALLOC;
						state_q    <= ST_IDLE;
					end else if (k_q == '0) begin
						state_q <= ST_OPEN;
					end else begin
						k_q <= k_q - PIDX_W'(1);
					end
				end
				ST_OPEN: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
					if (!table_full) begin
						granted      <= 1'b1;
						res_page     <= open_ext[pba_pkg::PAGE_W-1:0];
						moved        <= type_q == pba_pkg::REQ_REALLOC;
						pages_open_q <= pages_open_q + PO_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;

	// result beat only leaves once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while sequencer busy");

	// open page count never passes the table size
	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_open_q <= PO_W'(MAX_PAGES))
		else $error("open page count beyond table size");

	// a refused beat carries no placement
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !granted |-> res_page == '0 && res_offset == '0 && !moved)
		else $error("refused beat with nonzero fields");

	// the open count only grows on a page opening that is granted
	a_open_grant: assert property (@(posedge clk) disable iff (!arst_n)
		pages_open_q != $past(pages_open_q) |-> done && granted)
		else $error("page count changed without a granted beat");

endmodule

/* rtl/pba_page_mem.sv */
// page table memory: one entry per page holding size, fill and last block start
module pba_page_mem #(
	parameter int unsigned DEPTH  = pba_pkg::MAX_PAGES_DEF,
	parameter int unsigned IDX_W  = 4,
	parameter int unsigned DATA_W = 3 * pba_pkg::LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
